>>> rtl/core/gmdc_pkg.sv
`default_nettype none

package gmdc_pkg;

	// Default grid capacity
	localparam int DEF_MAX_COLS = 64;
	localparam int DEF_MAX_ROWS = 64;

	// Configuration registers
	localparam int CFG_W = 7;
	localparam logic [CFG_W-1:0] CFG_DIM_RESET = 7'd11;
	localparam logic REG_GRID_WIDTH  = 1'b0;
	localparam logic REG_GRID_HEIGHT = 1'b1;

	// Coordinate width on the ports
	localparam int COORD_W = 6;

	// Function codes
	localparam logic [1:0] FUNC_STEP    = 2'd0;
	localparam logic [1:0] FUNC_READ    = 2'd1;
	localparam logic [1:0] FUNC_RESTART = 2'd2;

	// Direction codes, also the bit index in the open mask
	localparam logic [1:0] DIR_WEST  = 2'd0;
	localparam logic [1:0] DIR_SOUTH = 2'd1;
	localparam logic [1:0] DIR_EAST  = 2'd2;
	localparam logic [1:0] DIR_NORTH = 2'd3;
	localparam logic [1:0] DIR_FLIP  = 2'd2;

	// Wall bit positions and init values
	localparam int WALL_N = 1;
	localparam int WALL_E = 0;
	localparam logic [1:0] WALL_BOTH = 2'b11;
	localparam logic [3:0] OPEN_ALL  = 4'hF;

	typedef struct packed {
		logic [1:0]         func;
		logic [1:0]         draw;
		logic [COORD_W-1:0] read_x;
		logic [COORD_W-1:0] read_y;
	} item_t;

	typedef struct packed {
		logic [COORD_W-1:0] cur_x;
		logic [COORD_W-1:0] cur_y;
		logic               carved;
		logic               backtracked;
		logic               done_res;
		logic               north_wall;
		logic               east_wall;
	} res_t;

	// One grid cell as held in the store
	typedef struct packed {
		logic [1:0] walls;
		logic [3:0] open;
		logic       visited;
		logic [1:0] parent;
	} cell_t;

	localparam int CELL_W = $bits(cell_t);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_READ,
		ST_CUR,
		ST_NB,
		ST_WNB,
		ST_REPORT
	} state_t;

	typedef enum logic [1:0] {
		RD_WALK,
		RD_READ,
		RD_NEXT
	} rd_sel_t;

	typedef enum logic [2:0] {
		WR_NONE,
		WR_SWEEP,
		WR_CLOSE_NOW,
		WR_CLOSE,
		WR_OPEN_CUR,
		WR_OPEN_NB
	} wr_op_t;

	typedef enum logic [1:0] {
		RES_PLAIN,
		RES_WALLS,
		RES_BACK,
		RES_CARVE
	} res_op_t;

	typedef struct packed {
		logic    take;
		logic    restart;
		logic    rd_en;
		rd_sel_t rd_sel;
		wr_op_t  wr_op;
		logic    sweep_adv;
		logic    cur_cap;
		logic    nb_cap;
		logic    fire;
		res_op_t res_op;
	} ctl_cmd_t;

	typedef struct packed {
		logic finished;
		logic read_hit;
		logic sweep_last;
		logic open_zero;
		logic draw_open;
		logic nb_ok;
		logic nb_visited;
		logic out_free;
	} dp_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/gmdc_ram.sv
`default_nettype none

module gmdc_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read; hold the last word when idle
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/gmdc_ctrl.sv
`default_nettype none

module gmdc_ctrl
	import gmdc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       item_valid,
	input  wire logic [1:0] item_func,
	input  wire dp_stat_t   stat,
	output ctl_cmd_t        cmd,
	output logic            item_stall
);

	state_t state_q;
	state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign item_stall = (state_q != ST_IDLE);

	// Next state and commands
	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		cmd.rd_sel    = RD_WALK;
		cmd.wr_op     = WR_NONE;
		cmd.res_op    = RES_PLAIN;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					cmd.take = 1'b1;
					case (item_func)
						FUNC_RESTART: begin
							cmd.restart = 1'b1;
							state_d     = ST_CLEAR;
						end
						FUNC_READ: begin
							if (stat.read_hit) begin
								cmd.rd_en  = 1'b1;
								cmd.rd_sel = RD_READ;
								state_d    = ST_READ;
							end else begin
								state_d = ST_REPORT;
							end
						end
						FUNC_STEP: begin
							if (!stat.finished) begin
								cmd.rd_en  = 1'b1;
								cmd.rd_sel = RD_WALK;
								state_d    = ST_CUR;
							end else begin
								state_d = ST_REPORT;
							end
						end
						default: begin
							state_d = ST_REPORT;
						end
					endcase
				end
			end
			ST_CLEAR: begin
				cmd.wr_op     = WR_SWEEP;
				cmd.sweep_adv = 1'b1;
				if (stat.sweep_last) begin
					state_d = ST_REPORT;
				end
			end
			ST_READ: begin
				cmd.res_op = RES_WALLS;
				if (stat.out_free) begin
					cmd.fire = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_CUR: begin
				cmd.cur_cap = 1'b1;
				cmd.nb_cap  = 1'b1;
				if (stat.open_zero) begin
					// dead end: back up to the parent
					cmd.res_op = RES_BACK;
					if (stat.out_free) begin
						cmd.fire = 1'b1;
						state_d  = ST_IDLE;
					end
				end else if (!stat.draw_open) begin
					if (stat.out_free) begin
						cmd.fire = 1'b1;
						state_d  = ST_IDLE;
					end
				end else if (!stat.nb_ok) begin
					// close a direction that leaves the grid
					if (stat.out_free) begin
						cmd.wr_op = WR_CLOSE_NOW;
						cmd.fire  = 1'b1;
						state_d   = ST_IDLE;
					end
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_NEXT;
					state_d    = ST_NB;
				end
			end
			ST_NB: begin
				if (stat.nb_visited) begin
					if (stat.out_free) begin
						cmd.wr_op = WR_CLOSE;
						cmd.fire  = 1'b1;
						state_d   = ST_IDLE;
					end
				end else begin
					cmd.wr_op = WR_OPEN_CUR;
					state_d   = ST_WNB;
				end
			end
			ST_WNB: begin
				cmd.res_op = RES_CARVE;
				if (stat.out_free) begin
					cmd.wr_op = WR_OPEN_NB;
					cmd.fire  = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			ST_REPORT: begin
				if (stat.out_free) begin
					cmd.fire = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/core/gmdc_datapath.sv
`default_nettype none

module gmdc_datapath
	import gmdc_pkg::*;
#(
	parameter int MAX_COLS = DEF_MAX_COLS,
	parameter int MAX_ROWS = DEF_MAX_ROWS
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic             cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data,
	input  wire item_t            item,
	input  wire ctl_cmd_t         cmd,
	output dp_stat_t              stat,
	output logic                  res_valid,
	input  wire logic             res_stall,
	output res_t                  res
);

	localparam int XW = $clog2(MAX_COLS);
	localparam int YW = $clog2(MAX_ROWS);
	localparam int AW = XW + YW;
	localparam int DEPTH = 1 << AW;
	localparam int DW = ((XW > CFG_W) ? XW : CFG_W) + 1;
	localparam logic [CFG_W-1:0] COL_CAP =
		(MAX_COLS >= (1 << CFG_W)) ? {CFG_W{1'b1}} : CFG_W'(MAX_COLS);
	localparam logic [CFG_W-1:0] ROW_CAP =
		(MAX_ROWS >= (1 << CFG_W)) ? {CFG_W{1'b1}} : CFG_W'(MAX_ROWS);

	logic [CFG_W-1:0] cfg_w_q, cfg_h_q;
	logic [CFG_W-1:0] used_w_q, used_h_q;
	logic [CFG_W-1:0] clamp_w, clamp_h;
	logic [XW-1:0]    walk_x_q, walk_x_d, sx_q, nbx_q, nb_x;
	logic [YW-1:0]    walk_y_q, walk_y_d, sy_q, nby_q, nb_y;
	logic             fin_q, fin_d;
	logic [1:0]       draw_q;
	cell_t            cur_q, rd_cell, wr_cell;
	logic [CELL_W-1:0] rd_data;
	logic [AW-1:0]    rd_addr, wr_addr;
	logic             wr_en;
	logic [1:0]       step_dir;
	logic [DW-1:0]    nxw, nyw;
	logic             nb_edge_ok, nb_ok;
	logic [3:0]       close_mask;
	logic             sx_last, sy_last;
	logic             res_valid_q;
	res_t             res_q, res_d;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_w_q <= CFG_DIM_RESET;
			cfg_h_q <= CFG_DIM_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_GRID_WIDTH) begin
				cfg_w_q <= cfg_data;
			end
			if (cfg_index == REG_GRID_HEIGHT) begin
				cfg_h_q <= cfg_data;
			end
		end
	end

	// Clamp the grid size taken at restart
	always_comb begin
		clamp_w = (cfg_w_q == '0) ? CFG_W'(1) : ((cfg_w_q > COL_CAP) ? COL_CAP : cfg_w_q);
		clamp_h = (cfg_h_q == '0) ? CFG_W'(1) : ((cfg_h_q > ROW_CAP) ? ROW_CAP : cfg_h_q);
	end

	assign rd_cell = cell_t'(rd_data);

	// Neighbor of the walk position: parent on a dead end, else the draw
	assign step_dir = (rd_cell.open == '0) ? rd_cell.parent : draw_q;

	always_comb begin
		nxw        = DW'(walk_x_q);
		nyw        = DW'(walk_y_q);
		nb_edge_ok = 1'b1;
		case (step_dir)
			DIR_WEST: begin
				nb_edge_ok = (walk_x_q != '0);
				nxw        = DW'(walk_x_q) - DW'(1);
			end
			DIR_SOUTH: begin
				nyw = DW'(walk_y_q) + DW'(1);
			end
			DIR_EAST: begin
				nxw = DW'(walk_x_q) + DW'(1);
			end
			default: begin
				nb_edge_ok = (walk_y_q != '0);
				nyw        = DW'(walk_y_q) - DW'(1);
			end
		endcase
		nb_ok = nb_edge_ok && (nxw < DW'(used_w_q)) && (nyw < DW'(used_h_q));
		nb_x  = nxw[XW-1:0];
		nb_y  = nyw[YW-1:0];
	end

	// Clearing sweep position
	assign sx_last = (DW'(sx_q) == DW'(used_w_q) - DW'(1));
	assign sy_last = (DW'(sy_q) == DW'(used_h_q) - DW'(1));

	// Read address
	always_comb begin
		case (cmd.rd_sel)
			RD_READ: rd_addr = {YW'(item.read_y), XW'(item.read_x)};
			RD_NEXT: rd_addr = {nb_y, nb_x};
			default: rd_addr = {walk_y_q, walk_x_q};
		endcase
	end

	assign close_mask = ~(4'b0001 << draw_q);

	// Write address and word
	always_comb begin
		wr_cell = cur_q;
		wr_addr = {walk_y_q, walk_x_q};
		case (cmd.wr_op)
			WR_SWEEP: begin
				wr_addr         = {sy_q, sx_q};
				wr_cell.walls   = WALL_BOTH;
				wr_cell.open    = OPEN_ALL;
				wr_cell.visited = (sx_q == '0) && (sy_q == '0);
				wr_cell.parent  = DIR_WEST;
				if (sy_q == '0) begin
					wr_cell.open[DIR_NORTH] = 1'b0;
				end
				if (sy_last) begin
					wr_cell.open[DIR_SOUTH] = 1'b0;
				end
				if (sx_q == '0) begin
					wr_cell.open[DIR_WEST] = 1'b0;
				end
				if (sx_last) begin
					wr_cell.open[DIR_EAST] = 1'b0;
				end
			end
			WR_CLOSE_NOW: begin
				wr_cell      = rd_cell;
				wr_cell.open = rd_cell.open & close_mask;
			end
			WR_CLOSE: begin
				wr_cell.open = cur_q.open & close_mask;
			end
			WR_OPEN_CUR: begin
				wr_cell.open = cur_q.open & close_mask;
				if (draw_q == DIR_NORTH) begin
					wr_cell.walls[WALL_N] = 1'b0;
				end
				if (draw_q == DIR_EAST) begin
					wr_cell.walls[WALL_E] = 1'b0;
				end
			end
			WR_OPEN_NB: begin
				wr_addr         = {nby_q, nbx_q};
				wr_cell         = rd_cell;
				wr_cell.visited = 1'b1;
				wr_cell.parent  = draw_q ^ DIR_FLIP;
				if (draw_q == DIR_SOUTH) begin
					wr_cell.walls[WALL_N] = 1'b0;
				end
				if (draw_q == DIR_WEST) begin
					wr_cell.walls[WALL_E] = 1'b0;
				end
			end
			default: begin
				wr_cell = cur_q;
			end
		endcase
	end

	assign wr_en = (cmd.wr_op != WR_NONE);

	gmdc_ram #(
		.WIDTH (CELL_W),
		.DEPTH (DEPTH)
	) u_cells (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_cell),
		.rd_en   (cmd.rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Walk position and done flag after this item
	always_comb begin
		walk_x_d = walk_x_q;
		walk_y_d = walk_y_q;
		fin_d    = fin_q;
		case (cmd.res_op)
			RES_BACK: begin
				if ((walk_x_q == '0) && (walk_y_q == '0)) begin
					fin_d = 1'b1;
				end else if (nb_ok) begin
					walk_x_d = nb_x;
					walk_y_d = nb_y;
					fin_d    = (nb_x == '0) && (nb_y == '0);
				end else begin
					fin_d = 1'b1;
				end
			end
			RES_CARVE: begin
				walk_x_d = nbx_q;
				walk_y_d = nby_q;
			end
			default: begin
				fin_d = fin_q;
			end
		endcase
	end

	// Result word
	always_comb begin
		res_d             = '0;
		res_d.cur_x       = COORD_W'(walk_x_d);
		res_d.cur_y       = COORD_W'(walk_y_d);
		res_d.carved      = (cmd.res_op == RES_CARVE);
		res_d.backtracked = (cmd.res_op == RES_BACK);
		res_d.done_res    = fin_d;
		if (cmd.res_op == RES_WALLS) begin
			res_d.north_wall = rd_cell.walls[WALL_N];
			res_d.east_wall  = rd_cell.walls[WALL_E];
		end
	end

	// Control state: grid size, walk, done flag, sweep position, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_w_q    <= '0;
			used_h_q    <= '0;
			walk_x_q    <= '0;
			walk_y_q    <= '0;
			fin_q       <= 1'b1;
			sx_q        <= '0;
			sy_q        <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.restart) begin
				used_w_q <= clamp_w;
				used_h_q <= clamp_h;
				walk_x_q <= '0;
				walk_y_q <= '0;
				fin_q    <= 1'b0;
				sx_q     <= '0;
				sy_q     <= '0;
			end else if (cmd.sweep_adv) begin
				if (sx_last) begin
					sx_q <= '0;
					sy_q <= sy_q + YW'(1);
				end else begin
					sx_q <= sx_q + XW'(1);
				end
			end
			if (cmd.fire) begin
				walk_x_q    <= walk_x_d;
				walk_y_q    <= walk_y_d;
				fin_q       <= fin_d;
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			draw_q <= item.draw;
		end
		if (cmd.cur_cap) begin
			cur_q <= rd_cell;
		end
		if (cmd.nb_cap) begin
			nbx_q <= nb_x;
			nby_q <= nb_y;
		end
		if (cmd.fire) begin
			res_q <= res_d;
		end
	end

	// Status to the controller
	always_comb begin
		stat            = '0;
		stat.finished   = fin_q;
		stat.read_hit   = (DW'(item.read_x) < DW'(used_w_q)) &&
		                  (DW'(item.read_y) < DW'(used_h_q));
		stat.sweep_last = sx_last && sy_last;
		stat.open_zero  = (rd_cell.open == '0);
		stat.draw_open  = rd_cell.open[draw_q];
		stat.nb_ok      = nb_ok;
		stat.nb_visited = rd_cell.visited;
		stat.out_free   = !res_valid_q || !res_stall;
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

`default_nettype wire

>>> rtl/core/grid_maze_dfs_carver_unit.sv
// Channel  Direction  Handshake                Word
// item     in         item_valid / item_stall  item_t: func, draw, read_x, read_y
// res      out        res_valid / res_stall    res_t: position, step flags, walls
// cfg      in         cfg_we                   cfg_index, cfg_data (7 bits)
//
// One item at a time. A walk step reads the current cell, then as needed reads
// the neighbor, writes the current cell and writes the neighbor, all through the one
// read and one write port of the cell store. A restart sweeps the grid, one cell a cycle.
// Reset is asynchronous, active low; the cell store needs no clearing.
// A held result stalls only the final state of the next item, where it fires.
`default_nettype none

module grid_maze_dfs_carver_unit
	import gmdc_pkg::*;
#(
	parameter int MAX_COLS = DEF_MAX_COLS,
	parameter int MAX_ROWS = DEF_MAX_ROWS
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic             cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data,
	input  wire logic             item_valid,
	output logic                  item_stall,
	input  wire item_t            item,
	output logic                  res_valid,
	input  wire logic             res_stall,
	output res_t                  res
);

	ctl_cmd_t cmd;
	dp_stat_t stat;

	gmdc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_func  (item.func),
		.stat       (stat),
		.cmd        (cmd),
		.item_stall (item_stall)
	);

	gmdc_datapath #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item),
		.cmd       (cmd),
		.stat      (stat),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule

`default_nettype wire

>>> rtl/core/gmdc_checker.sv
`default_nettype none

module gmdc_checker
	import gmdc_pkg::*;
(
	input wire logic  clk,
	input wire logic  arst_n,
	input wire logic  item_valid,
	input wire logic  item_stall,
	input wire logic  res_valid,
	input wire logic  res_stall,
	input wire res_t  res
);

	// Hold a stalled result word
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("stalled result word changed");

	// Every accepted item makes the block stall the item channel, so items are never taken back to back
	assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("item accepted on back-to-back cycles");

	// A step never both carves and backs up, and a carving or backing step never reports walls
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res.carved && res.backtracked) &&
		!((res.north_wall || res.east_wall) && (res.carved || res.backtracked)))
		else $error("conflicting result flags");

	// A carve moves away from the root and leaves the walk running
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.carved |-> !res.done_res &&
		((res.cur_x != '0) || (res.cur_y != '0)))
		else $error("carve reported done or root position");

endmodule

bind grid_maze_dfs_carver_unit gmdc_checker u_gmdc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.item_valid (item_valid),
	.item_stall (item_stall),
	.res_valid  (res_valid),
	.res_stall  (res_stall),
	.res        (res)
);

`default_nettype wire

>>> test/grid_maze_dfs_carver_unit_tb.sv
`timescale 1ns / 1ps
`default_nettype none

module grid_maze_dfs_carver_unit_tb;
	import gmdc_pkg::*;

	// Function code with no meaning: the block reports status only
	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int CELLS = DEF_MAX_COLS * DEF_MAX_ROWS;
	localparam int HOLD_CYCLES = 300;
	localparam int RANDOM_ITEMS = 1550;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic             cfg_index = REG_GRID_WIDTH;
	logic [CFG_W-1:0] cfg_data = '0;
	logic             item_valid = 1'b0;
	logic             item_stall;
	item_t            item = '0;
	logic             res_valid;
	logic             res_stall = 1'b0;
	res_t             res;

	grid_maze_dfs_carver_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item      (item),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	always #2 clk = ~clk;

	// Shadow of the grid and the walk
	bit [1:0]   wall_mem [CELLS];
	bit [3:0]   open_mem [CELLS];
	bit         seen_mem [CELLS];
	bit [1:0]   parent_mem [CELLS];
	bit [5:0]   pos_x = '0;
	bit [5:0]   pos_y = '0;
	bit         walk_done = 1'b1;
	bit [6:0]   width_reg = CFG_DIM_RESET;
	bit [6:0]   height_reg = CFG_DIM_RESET;
	int         grid_w = 0;
	int         grid_h = 0;

	item_t      pending_items [$];
	res_t       expected_res [$];
	res_t       want;
	int         fail_count = 0;
	int         send_idle_pct = 0;
	int         stall_pct = 0;
	int         hold_epoch = 0;
	int         hold_seen = 0;
	int         hold_left = 0;

	// Stimulus-side view of the grid size latched at the last queued restart
	int         lat_w = 0;
	int         lat_h = 0;

	function automatic int clamp_dim(input int v, input int maxv);
		if (v == 0)
			return 1;
		if (v > maxv)
			return maxv;
		return v;
	endfunction

	// Neighbor in direction d; 0 when it leaves the latched grid
	function automatic bit step_to(input int x, input int y, input logic [1:0] d,
			output int nx, output int ny);
		nx = x;
		ny = y;
		case (d)
			DIR_WEST: begin
				if (x == 0)
					return 1'b0;
				nx = x - 1;
			end
			DIR_SOUTH: ny = y + 1;
			DIR_EAST:  nx = x + 1;
			default: begin
				if (y == 0)
					return 1'b0;
				ny = y - 1;
			end
		endcase
		return (nx < grid_w) && (ny < grid_h);
	endfunction

	// Advance the shadow by one word and queue the result it must produce
	task automatic carve_step_predict(input item_t it);
		res_t r;
		int   ci;
		int   ni;
		int   nx;
		int   ny;
		bit [3:0] od;
		r = '0;
		ci = pos_y * DEF_MAX_COLS + pos_x;
		if (it.func == FUNC_RESTART) begin
			grid_w = clamp_dim(width_reg, DEF_MAX_COLS);
			grid_h = clamp_dim(height_reg, DEF_MAX_ROWS);
			for (int y = 0; y < grid_h; y++) begin
				for (int x = 0; x < grid_w; x++) begin
					od = OPEN_ALL;
					if (y == 0)
						od[DIR_NORTH] = 1'b0;
					if (y == grid_h - 1)
						od[DIR_SOUTH] = 1'b0;
					if (x == 0)
						od[DIR_WEST] = 1'b0;
					if (x == grid_w - 1)
						od[DIR_EAST] = 1'b0;
					wall_mem[y * DEF_MAX_COLS + x] = WALL_BOTH;
					open_mem[y * DEF_MAX_COLS + x] = od;
					seen_mem[y * DEF_MAX_COLS + x] = 1'b0;
					parent_mem[y * DEF_MAX_COLS + x] = '0;
				end
			end
			seen_mem[0] = 1'b1;
			pos_x = '0;
			pos_y = '0;
			walk_done = 1'b0;
		end else if (it.func == FUNC_READ) begin
			if (it.read_x < grid_w && it.read_y < grid_h) begin
				r.north_wall = wall_mem[it.read_y * DEF_MAX_COLS + it.read_x][WALL_N];
				r.east_wall  = wall_mem[it.read_y * DEF_MAX_COLS + it.read_x][WALL_E];
			end
		end else if (it.func == FUNC_STEP && !walk_done) begin
			if (open_mem[ci] == '0) begin
				// Dead end: go back to the parent, done at the root
				r.backtracked = 1'b1;
				if (pos_x == 0 && pos_y == 0) begin
					walk_done = 1'b1;
				end else if (step_to(pos_x, pos_y, parent_mem[ci], nx, ny)) begin
					pos_x = COORD_W'(nx);
					pos_y = COORD_W'(ny);
					if (nx == 0 && ny == 0)
						walk_done = 1'b1;
				end else begin
					walk_done = 1'b1;
				end
			end else if (open_mem[ci][it.draw]) begin
				// Close the drawn direction; carve only into a fresh neighbor
				open_mem[ci][it.draw] = 1'b0;
				if (step_to(pos_x, pos_y, it.draw, nx, ny)) begin
					ni = ny * DEF_MAX_COLS + nx;
					if (!seen_mem[ni]) begin
						case (it.draw)
							DIR_NORTH: wall_mem[ci][WALL_N] = 1'b0;
							DIR_EAST:  wall_mem[ci][WALL_E] = 1'b0;
							DIR_SOUTH: wall_mem[ni][WALL_N] = 1'b0;
							default:   wall_mem[ni][WALL_E] = 1'b0;
						endcase
						seen_mem[ni] = 1'b1;
						parent_mem[ni] = it.draw ^ DIR_FLIP;
						pos_x = COORD_W'(nx);
						pos_y = COORD_W'(ny);
						r.carved = 1'b1;
					end
				end
			end
		end
		r.cur_x = pos_x;
		r.cur_y = pos_y;
		r.done_res = walk_done;
		expected_res.push_back(r);
	endtask

	// Driver: offer words from the pending queue, idle at random
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall)
				carve_step_predict(item);
			if (!item_valid || !item_stall) begin
				if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					item <= pending_items.pop_front();
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, actual %0d", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	// Monitor: compare each accepted word with the oldest prediction, and drive the result stall
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				if (expected_res.size() == 0) begin
					$error("result word with no prediction waiting");
					fail_count++;
				end else begin
					want = expected_res.pop_front();
					check_field("cur_x", want.cur_x, res.cur_x);
					check_field("cur_y", want.cur_y, res.cur_y);
					check_field("carved", want.carved, res.carved);
					check_field("backtracked", want.backtracked, res.backtracked);
					check_field("done_res", want.done_res, res.done_res);
					check_field("north_wall", want.north_wall, res.north_wall);
					check_field("east_wall", want.east_wall, res.east_wall);
				end
			end
			if (hold_epoch != hold_seen) begin
				hold_seen = hold_epoch;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0)
				hold_left--;
			res_stall <= (hold_left > 0) || ($urandom_range(99) < stall_pct);
		end
	end

	function automatic void push_item(input logic [1:0] func, input logic [1:0] draw,
			input int rx, input int ry);
		item_t it;
		it.func = func;
		it.draw = draw;
		it.read_x = COORD_W'(rx);
		it.read_y = COORD_W'(ry);
		if (func == FUNC_RESTART) begin
			lat_w = clamp_dim(width_reg, DEF_MAX_COLS);
			lat_h = clamp_dim(height_reg, DEF_MAX_ROWS);
		end
		pending_items.push_back(it);
	endfunction

	task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_GRID_WIDTH)
			width_reg = val;
		else
			height_reg = val;
	endtask

	// Wait until every queued word is sent and every result has come back
	task automatic drain();
		@(negedge clk);
		while (pending_items.size() != 0 || item_valid || expected_res.size() != 0)
			@(negedge clk);
	endtask

	// Mostly steps with random draws, mixed with reads, noise and the odd restart
	task automatic queue_walk(input int steps);
		int pick;
		for (int i = 0; i < steps; i++) begin
			pick = $urandom_range(99);
			if (pick < 80)
				push_item(FUNC_STEP, 2'($urandom_range(3)), $urandom_range(63),
					$urandom_range(63));
			else if (pick < 92)
				push_item(FUNC_READ, 2'($urandom_range(3)), $urandom_range(lat_w - 1),
					$urandom_range(lat_h - 1));
			else if (pick < 96)
				push_item(FUNC_READ, 2'($urandom_range(3)), $urandom_range(63),
					$urandom_range(63));
			else if (pick < 99)
				push_item(FUNC_UNUSED, 2'($urandom_range(3)), $urandom_range(63),
					$urandom_range(63));
			else
				push_item(FUNC_RESTART, 2'($urandom_range(3)), $urandom_range(63),
					$urandom_range(63));
		end
	endtask

	function automatic logic [CFG_W-1:0] pick_dim();
		case ($urandom_range(19))
			0: return 7'd0;
			1: return 7'd64;
			2: return 7'd65;
			3: return 7'd127;
			4: return 7'd2;
			default: return CFG_W'($urandom_range(6, 1));
		endcase
	endfunction

	initial begin
		int queued;
		int area;
		int round;
		int walk_len;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Before any restart: the walk is done, steps change nothing
		push_item(FUNC_STEP, DIR_EAST, 0, 0);
		push_item(FUNC_UNUSED, DIR_NORTH, 63, 63);
		// Default 11 x 11 grid, every draw and some reads
		push_item(FUNC_RESTART, DIR_WEST, 0, 0);
		push_item(FUNC_STEP, DIR_NORTH, 0, 0);
		push_item(FUNC_STEP, DIR_WEST, 0, 0);
		push_item(FUNC_STEP, DIR_EAST, 63, 0);
		push_item(FUNC_STEP, DIR_WEST, 0, 63);
		push_item(FUNC_STEP, DIR_SOUTH, 0, 0);
		push_item(FUNC_STEP, DIR_NORTH, 0, 0);
		push_item(FUNC_READ, DIR_WEST, 0, 0);
		push_item(FUNC_READ, DIR_WEST, 1, 0);
		push_item(FUNC_READ, DIR_WEST, 10, 10);
		push_item(FUNC_READ, DIR_WEST, 11, 0);
		push_item(FUNC_READ, DIR_NORTH, 63, 63);
		push_item(FUNC_UNUSED, DIR_SOUTH, 5, 5);
		drain();

		// Zero dimensions count as one: the root backtracks and is done
		write_reg(REG_GRID_WIDTH, 7'd0);
		write_reg(REG_GRID_HEIGHT, 7'd0);
		push_item(FUNC_RESTART, DIR_EAST, 0, 0);
		push_item(FUNC_STEP, DIR_EAST, 0, 0);
		push_item(FUNC_STEP, DIR_SOUTH, 0, 0);
		push_item(FUNC_READ, DIR_WEST, 0, 0);
		push_item(FUNC_READ, DIR_WEST, 1, 0);
		drain();

		// Oversized dimensions count as the maximum
		write_reg(REG_GRID_WIDTH, 7'd127);
		write_reg(REG_GRID_HEIGHT, 7'd65);
		push_item(FUNC_RESTART, DIR_NORTH, 63, 63);
		push_item(FUNC_STEP, DIR_SOUTH, 0, 0);
		push_item(FUNC_STEP, DIR_EAST, 0, 0);
		push_item(FUNC_READ, DIR_EAST, 63, 63);
		push_item(FUNC_READ, DIR_EAST, 0, 1);
		drain();

		// Random rounds: new size, a walk, idle mode rotating per round
		queued = 0;
		round = 0;
		while (queued < RANDOM_ITEMS) begin
			write_reg(REG_GRID_WIDTH, pick_dim());
			write_reg(REG_GRID_HEIGHT, pick_dim());
			case (round % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 53; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 53; end
				default: begin send_idle_pct = 35; stall_pct = 35; end
			endcase
			// Keep the old grid now and then; the new size waits for a restart
			if (round % 5 != 4) begin
				push_item(FUNC_RESTART, 2'($urandom_range(3)), $urandom_range(63),
					$urandom_range(63));
				queued++;
			end
			area = lat_w * lat_h;
			if (area <= 36)
				walk_len = 10 * area + $urandom_range(30);
			else
				walk_len = 200;
			queue_walk(walk_len);
			queued += walk_len;
			// Hold the result side off while the sender keeps offering
			if (round == 3) begin
				send_idle_pct = 0;
				hold_epoch++;
			end
			drain();
			round++;
		end

		repeat (50) @(posedge clk);
		if (fail_count == 0)
			$display("grid_maze_dfs_carver_unit_tb OK");
		else
			$display("grid_maze_dfs_carver_unit_tb NOT OK");
		$finish;
	end

	// Drop the run if it hangs
	initial begin
		#4000000;
		$display("grid_maze_dfs_carver_unit_tb NOT OK");
		$finish;
	end

endmodule

`default_nettype wire

>>> files.f
rtl/core/gmdc_pkg.sv
rtl/core/gmdc_ram.sv
rtl/core/gmdc_ctrl.sv
rtl/core/gmdc_datapath.sv
rtl/core/grid_maze_dfs_carver_unit.sv
rtl/core/gmdc_checker.sv
test/grid_maze_dfs_carver_unit_tb.sv
